### src/bcd_pkg.sv
// bcd_pkg: shared types, format codes and fixed-point helpers for the
// texture block decoder (palette division by constant reciprocals).
// No dependencies.
package bcd_pkg;

   // block_format codes
   localparam logic [1:0] FMT_DXT1         = 2'd0;
   localparam logic [1:0] FMT_DXT5         = 2'd1;
   localparam logic [1:0] FMT_DXT5_ORDERED = 2'd2;
   localparam logic [1:0] FMT_CTX1         = 2'd3;

   // register index decoded from the csr address
   localparam logic CSR_IDX_BLOCK_FORMAT = 1'b0;

   // reciprocals: n/3 = (n*683)>>11 for n<=765, n/5 = (n*3277)>>14 and
   // n/7 = (n*2341)>>14 for n<=1785
   localparam logic [9:0]  DIV3_RECIP = 10'd683;
   localparam logic [11:0] DIV5_RECIP = 12'd3277;
   localparam logic [11:0] DIV7_RECIP = 12'd2341;

   typedef struct packed {
      logic [1:0]  fmt;
      logic [15:0] alpha_ends;
      logic [47:0] alpha_sels;
      logic [63:0] word;
   } entry_type;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } texel_type;

   function automatic logic [7:0] div3(input logic [9:0] n);
      logic [19:0] p;
      p = n * DIV3_RECIP;
      return p[18:11];
   endfunction

   function automatic logic [7:0] div5(input logic [10:0] n);
      logic [22:0] p;
      p = n * DIV5_RECIP;
      return p[21:14];
   endfunction

   function automatic logic [7:0] div7(input logic [10:0] n);
      logic [22:0] p;
      p = n * DIV7_RECIP;
      return p[21:14];
   endfunction

   // (2a + b) / 3
   function automatic logic [7:0] third(input logic [7:0] a, input logic [7:0] b);
      logic [9:0] s;
      s = {1'b0, a, 1'b0} + {2'b00, b};
      return div3(s);
   endfunction

   // (a + b) / 2
   function automatic logic [7:0] half(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[8:1];
   endfunction

   function automatic texel_type expand565(input logic [15:0] c);
      texel_type t;
      t.red   = {c[15:11], c[15:13]};
      t.green = {c[10:5], c[10:9]};
      t.blue  = {c[4:0], c[4:2]};
      t.alpha = 8'd255;
      return t;
   endfunction

   // dxt5 alpha palette entry for one selector
   function automatic logic [7:0] alpha_value(input logic [15:0] ends,
                                              input logic [2:0] sel);
      logic [7:0]  a0;
      logic [7:0]  a1;
      logic [3:0]  w0;
      logic [3:0]  w1;
      logic [11:0] p0;
      logic [11:0] p1;
      logic [10:0] num;
      logic [7:0]  res;
      a0 = ends[7:0];
      a1 = ends[15:8];
      w1 = {1'b0, sel} - 4'd1;
      if (a0 > a1) begin
         w0 = 4'd8 - {1'b0, sel};
      end else begin
         w0 = 4'd6 - {1'b0, sel};
      end
      p0  = w0 * a0;
      p1  = w1 * a1;
      num = p0[10:0] + p1[10:0];
      if (sel == 3'd0) begin
         res = a0;
      end else if (sel == 3'd1) begin
         res = a1;
      end else if (a0 > a1) begin
         res = div7(num);
      end else if (sel == 3'd6) begin
         res = 8'd0;
      end else if (sel == 3'd7) begin
         res = 8'd255;
      end else begin
         res = div5(num);
      end
      return res;
   endfunction

endpackage

### src/bcd_front.sv
// bcd_front: accepts block words, keeps the alpha word of the current block
// and pushes each colour word with its alpha state into the queue.
// Depends on bcd_pkg.
module bcd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         block_format,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [63:0]        req_tdata,
   input  logic               queue_full,
   output logic               push_valid,
   output bcd_pkg::entry_type push_entry
);
   import bcd_pkg::*;

   logic        expect_colour_ff, expect_colour_in;
   logic [15:0] alpha_ends_ff, alpha_ends_in;
   logic [47:0] alpha_sels_ff, alpha_sels_in;
   logic        accept;
   logic        is_alpha;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign is_alpha   = (block_format != FMT_DXT1) && !expect_colour_ff;
   assign push_valid = accept && !is_alpha;

   always_comb begin
      push_entry.fmt        = block_format;
      push_entry.alpha_ends = alpha_ends_ff;
      push_entry.alpha_sels = alpha_sels_ff;
      push_entry.word       = req_tdata;
   end

   always_comb begin
      expect_colour_in = expect_colour_ff;
      alpha_ends_in    = alpha_ends_ff;
      alpha_sels_in    = alpha_sels_ff;
      if (accept) begin
         if (is_alpha) begin
            alpha_ends_in    = req_tdata[15:0];
            alpha_sels_in    = req_tdata[63:16];
            expect_colour_in = 1'b1;
         end else begin
            expect_colour_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_colour_ff <= 1'b0;
         alpha_ends_ff    <= '0;
         alpha_sels_ff    <= '0;
      end else begin
         expect_colour_ff <= expect_colour_in;
         alpha_ends_ff    <= alpha_ends_in;
         alpha_sels_ff    <= alpha_sels_in;
      end
   end

endmodule

### src/bcd_queue.sv
// bcd_queue: short first-in first-out queue of colour-word entries between
// the front and the back. Depends on bcd_pkg.
module bcd_queue #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  bcd_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output bcd_pkg::entry_type head_entry
);
   import bcd_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   entry_type     slots_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign full       = (count_ff == FULL_COUNT);
   assign head_valid = (count_ff != '0);
   assign head_entry = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### src/bcd_back.sv
// bcd_back: builds the colour palette of the queue head, then emits sixteen
// texels one per cycle, unless rsp stalls, through an output register. Depends on bcd_pkg.
module bcd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  bcd_pkg::entry_type head_entry,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [39:0]        rsp_tdata,
   output logic               rsp_tlast
);
   import bcd_pkg::*;

   texel_type   pal_ff [4];
   texel_type   pal_in [4];
   logic [31:0] sels_ff, sels_in;
   logic [15:0] alpha_ends_ff, alpha_ends_in;
   logic [47:0] alpha_sels_ff, alpha_sels_in;
   logic        pal_alpha_ff, pal_alpha_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        blk_valid_ff, blk_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   texel_type   rsp_texel_ff, rsp_texel_in;
   logic [3:0]  rsp_index_ff, rsp_index_in;
   logic        rsp_last_ff, rsp_last_in;

   texel_type   new_pal [4];
   texel_type   cur_texel;
   texel_type   e0;
   texel_type   e1;
   logic [63:0] w;
   logic        four;
   logic        emit;
   logic        blk_done;
   logic        load;

   // palette of the queue head
   always_comb begin
      w  = head_entry.word;
      e0 = expand565(w[15:0]);
      e1 = expand565(w[31:16]);
      four = (head_entry.fmt == FMT_DXT5) || (w[15:0] > w[31:16]);
      if (head_entry.fmt == FMT_CTX1) begin
         new_pal[0] = '{alpha: 8'd255, blue: 8'd0, green: w[15:8], red: w[7:0]};
         new_pal[1] = '{alpha: 8'd255, blue: 8'd0, green: w[31:24], red: w[23:16]};
         new_pal[2] = '{alpha: 8'd255, blue: 8'd0,
                        green: third(w[15:8], w[31:24]), red: third(w[7:0], w[23:16])};
         new_pal[3] = '{alpha: 8'd255, blue: 8'd0,
                        green: third(w[31:24], w[15:8]), red: third(w[23:16], w[7:0])};
      end else begin
         new_pal[0] = e0;
         new_pal[1] = e1;
         if (four) begin
            new_pal[2] = '{alpha: 8'd255, blue: third(e0.blue, e1.blue),
                           green: third(e0.green, e1.green), red: third(e0.red, e1.red)};
            new_pal[3] = '{alpha: 8'd255, blue: third(e1.blue, e0.blue),
                           green: third(e1.green, e0.green), red: third(e1.red, e0.red)};
         end else begin
            new_pal[2] = '{alpha: 8'd255, blue: half(e0.blue, e1.blue),
                           green: half(e0.green, e1.green), red: half(e0.red, e1.red)};
            // transparent black
            new_pal[3] = '0;
         end
      end
   end

   always_comb begin
      cur_texel = pal_ff[sels_ff[1:0]];
      if (!pal_alpha_ff) begin
         cur_texel.alpha = alpha_value(alpha_ends_ff, alpha_sels_ff[2:0]);
      end
   end

   assign emit     = blk_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign blk_done = emit && (cnt_ff == 4'd15);
   assign load     = head_valid && (!blk_valid_ff || blk_done);
   assign pop      = load;

   always_comb begin
      pal_in        = pal_ff;
      sels_in       = sels_ff;
      alpha_ends_in = alpha_ends_ff;
      alpha_sels_in = alpha_sels_ff;
      pal_alpha_in  = pal_alpha_ff;
      cnt_in        = cnt_ff;
      blk_valid_in  = blk_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_texel_in  = rsp_texel_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_texel_in  = cur_texel;
         rsp_index_in  = cnt_ff;
         rsp_last_in   = (cnt_ff == 4'd15);
         cnt_in        = cnt_ff + 4'd1;
         sels_in       = sels_ff >> 2;
         alpha_sels_in = alpha_sels_ff >> 3;
         if (blk_done) begin
            blk_valid_in = 1'b0;
         end
      end
      if (load) begin
         pal_in        = new_pal;
         sels_in       = w[63:32];
         alpha_ends_in = head_entry.alpha_ends;
         alpha_sels_in = head_entry.alpha_sels;
         pal_alpha_in  = (head_entry.fmt == FMT_DXT1);
         cnt_in        = 4'd0;
         blk_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         blk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         blk_valid_ff <= blk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pal_ff        <= pal_in;
      sels_ff       <= sels_in;
      alpha_ends_ff <= alpha_ends_in;
      alpha_sels_ff <= alpha_sels_in;
      pal_alpha_ff  <= pal_alpha_in;
      rsp_texel_ff  <= rsp_texel_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'b0000, rsp_texel_ff.alpha, rsp_texel_ff.blue,
                        rsp_texel_ff.green, rsp_texel_ff.red, rsp_index_ff};

endmodule

### src/bc_texture_block_decoder.sv
//  channel | direction | handshake              | payload
//  req     | in        | req_tvalid/req_tready  | tdata[63:0] block_word
//  rsp     | out       | rsp_tvalid/rsp_tready  | tdata index,r,g,b,a; tlast last_texel
//  csr     | in        | psel/penable/pwrite    | block_format at address 0
//
// An alpha word gives no texel. A colour word gives sixteen texels, one per cycle
// while rsp_tready does not stall the output register. After its colour word is
// taken, the first texel passes through the queue, the palette register and the
// output register. Reset clears the queue, the block state and the format register.
// Either side may stall; the queue of QUEUE_DEPTH colour words lets the front keep
// taking words while the back is held.
module bc_texture_block_decoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] block_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [3:0] texel_index, [11:4] red, [19:12] green,
                                    // [27:20] blue, [35:28] alpha, [39:36] zero
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bcd_pkg::*;

   logic [1:0] block_format_ff, block_format_in;
   logic       csr_write;
   logic       queue_full;
   logic       push_valid;
   entry_type  push_entry;
   logic       head_valid;
   entry_type  head_entry;
   logic       pop;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_BLOCK_FORMAT) ?
                       {30'd0, block_format_ff} : 32'd0;

   always_comb begin
      block_format_in = block_format_ff;
      if (csr_write && (csr_paddr[2] == CSR_IDX_BLOCK_FORMAT)) begin
         block_format_in = csr_pwdata[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_format_ff <= FMT_DXT1;
      end else begin
         block_format_ff <= block_format_in;
      end
   end

   bcd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .block_format (block_format_ff),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .queue_full   (queue_full),
      .push_valid   (push_valid),
      .push_entry   (push_entry)
   );

   bcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   bcd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   // last marker sits exactly on texel fifteen
   a_last_on_fifteen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[3:0] == 4'd15)))
      else $error("last marker not on texel fifteen");

   // texels of a block follow without gaps
   a_texel_sequence: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=>
      (rsp_tvalid && (rsp_tdata[3:0] == $past(rsp_tdata[3:0]) + 4'd1)))
      else $error("texel sequence broken inside a block");

   // nothing is pushed while the queue is full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !push_valid)
      else $error("push into full queue");
`endif

endmodule

### tb/bc_texture_block_decoder_test.sv
// bc_texture_block_decoder_test: self-checking bench for the texture block decoder.
// Predicts the sixteen texels of every colour word in all four block formats and
// checks them against the rsp stream; depends on bcd_pkg and the decoder RTL.
`timescale 1ns / 100ps

module bc_texture_block_decoder_test;
   import bcd_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [2:0] ADDR_BLOCK_FORMAT = 3'd0;
   localparam logic [2:0] ADDR_UNMAPPED = 3'd4;
   localparam logic [31:0] SEL_RAMP = 32'hE4E4_E4E4;

   typedef struct packed {
      logic [3:0] texel_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       last_texel;
   } exp_texel_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor state
   logic [1:0]    fmt_model;
   bit            colour_next;
   logic [15:0]   alpha_ends;
   logic [47:0]   alpha_sels;
   exp_texel_type texel_queue[$];

   int error_count = 0;
   int cycle_count = 0;
   int hold_rsp_cycles = 0;
   bit calm = 0;

   bc_texture_block_decoder uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [7:0] dxt5_alpha(input logic [2:0] sel);
      int unsigned a0;
      int unsigned a1;
      int unsigned s;
      a0 = alpha_ends[7:0];
      a1 = alpha_ends[15:8];
      s = sel;
      if (s == 0) return 8'(a0);
      if (s == 1) return 8'(a1);
      if (a0 > a1) return 8'(((8 - s) * a0 + (s - 1) * a1) / 7);
      if (s == 6) return 8'd0;
      if (s == 7) return 8'd255;
      return 8'(((6 - s) * a0 + (s - 1) * a1) / 5);
   endfunction

   // consumes one block word, queues the texels it produces
   function automatic void decode_word(input logic [63:0] w);
      int unsigned pal[4][4];
      int unsigned c0;
      int unsigned c1;
      bit four;
      bit from_palette;
      exp_texel_type t;
      logic [1:0] s;
      int k;
      int ch;
      if (fmt_model != FMT_DXT1 && !colour_next) begin
         alpha_ends = w[15:0];
         alpha_sels = w[63:16];
         colour_next = 1;
         return;
      end
      colour_next = 0;
      if (fmt_model == FMT_CTX1) begin
         for (ch = 0; ch < 2; ch++) begin
            pal[0][ch] = w[8 * ch +: 8];
            pal[1][ch] = w[16 + 8 * ch +: 8];
            pal[2][ch] = (2 * pal[0][ch] + pal[1][ch]) / 3;
            pal[3][ch] = (pal[0][ch] + 2 * pal[1][ch]) / 3;
         end
         for (k = 0; k < 4; k++) begin
            pal[k][2] = 0;
            pal[k][3] = 255;
         end
         from_palette = 0;
      end else begin
         c0 = w[15:0];
         c1 = w[31:16];
         four = (fmt_model == FMT_DXT5) || (c0 > c1);
         // rgb565 widened by replicating the top bits
         pal[0][0] = {w[15:11], w[15:13]};
         pal[0][1] = {w[10:5], w[10:9]};
         pal[0][2] = {w[4:0], w[4:2]};
         pal[1][0] = {w[31:27], w[31:29]};
         pal[1][1] = {w[26:21], w[26:25]};
         pal[1][2] = {w[20:16], w[20:18]};
         for (ch = 0; ch < 3; ch++) begin
            if (four) begin
               pal[2][ch] = (2 * pal[0][ch] + pal[1][ch]) / 3;
               pal[3][ch] = (pal[0][ch] + 2 * pal[1][ch]) / 3;
            end else begin
               pal[2][ch] = (pal[0][ch] + pal[1][ch]) / 2;
               pal[3][ch] = 0;
            end
         end
         pal[0][3] = 255;
         pal[1][3] = 255;
         pal[2][3] = 255;
         pal[3][3] = four ? 255 : 0;
         from_palette = (fmt_model == FMT_DXT1);
      end
      for (k = 0; k < 16; k++) begin
         s = w[32 + 2 * k +: 2];
         t.texel_index = 4'(k);
         t.red = 8'(pal[s][0]);
         t.green = 8'(pal[s][1]);
         t.blue = 8'(pal[s][2]);
         t.alpha = from_palette ? 8'(pal[s][3]) : dxt5_alpha(alpha_sels[3 * k +: 3]);
         t.last_texel = (k == 15);
         texel_queue.push_back(t);
      end
   endfunction

   // rsp side: compare every transaction with the oldest predicted texel
   always @(posedge clock) begin
      exp_texel_type exp_t;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (texel_queue.size() == 0) begin
            $error("unexpected texel transaction, tdata %h", rsp_tdata);
            error_count++;
         end else begin
            exp_t = texel_queue.pop_front();
            if (rsp_tdata[3:0] !== exp_t.texel_index) begin
               $error("texel_index exp %0d got %0d", exp_t.texel_index, rsp_tdata[3:0]);
               error_count++;
            end
            if (rsp_tdata[11:4] !== exp_t.red) begin
               $error("red exp %0d got %0d", exp_t.red, rsp_tdata[11:4]);
               error_count++;
            end
            if (rsp_tdata[19:12] !== exp_t.green) begin
               $error("green exp %0d got %0d", exp_t.green, rsp_tdata[19:12]);
               error_count++;
            end
            if (rsp_tdata[27:20] !== exp_t.blue) begin
               $error("blue exp %0d got %0d", exp_t.blue, rsp_tdata[27:20]);
               error_count++;
            end
            if (rsp_tdata[35:28] !== exp_t.alpha) begin
               $error("alpha exp %0d got %0d", exp_t.alpha, rsp_tdata[35:28]);
               error_count++;
            end
            if (rsp_tlast !== exp_t.last_texel) begin
               $error("last_texel exp %0d got %0d", exp_t.last_texel, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // rsp side ready: random stall bursts, plus a long hold-off on request
   initial begin
      int n;
      rsp_tready <= 1'b0;
      forever begin
         if (hold_rsp_cycles > 0) begin
            n = hold_rsp_cycles;
            hold_rsp_cycles = 0;
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_word(input logic [63:0] w);
      req_tvalid <= 1'b1;
      req_tdata <= w;
      do @(posedge clock); while (!req_tready);
      decode_word(w);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // stop offering words until every texel is out and the pipe has settled
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (texel_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (addr[2] == CSR_IDX_BLOCK_FORMAT) fmt_model = data[1:0];
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic csr_read_check();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= ADDR_BLOCK_FORMAT;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== {30'd0, fmt_model}) begin
         $error("block_format exp %0d got %0d", fmt_model, csr_prdata);
         error_count++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_format(input logic [1:0] f);
      csr_write(ADDR_BLOCK_FORMAT, {$urandom} & 32'hFFFF_FFFC | f);
   endtask

   // alpha word whose texel k uses selector k mod 8
   function automatic logic [63:0] alpha_word(input logic [7:0] a0, input logic [7:0] a1);
      logic [47:0] sels;
      int k;
      for (k = 0; k < 16; k++) sels[3 * k +: 3] = 3'(k % 8);
      return {sels, a1, a0};
   endfunction

   function automatic logic [63:0] random_word();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: w[31:16] = w[15:0];
         1: w[15:0] = 16'hFFFF;
         2: w[31:16] = 16'h0000;
         3: w[15:8] = w[7:0];
         4: w[63:32] = SEL_RAMP;
         default: ;
      endcase
      return w;
   endfunction

   task automatic test_csr();
      set_format(FMT_CTX1);
      csr_read_check();
      csr_write(ADDR_UNMAPPED, 32'h0000_0001);
      csr_read_check();
      set_format(FMT_DXT1);
      csr_read_check();
   endtask

   task automatic test_dxt1();
      set_format(FMT_DXT1);
      send_word(64'h0);
      send_word(64'hFFFF_FFFF_FFFF_FFFF);
      send_word({SEL_RAMP, 16'h07E0, 16'hF800});   // four-colour
      send_word({SEL_RAMP, 16'hF800, 16'h07E0});   // three-colour, transparent black
      send_word({SEL_RAMP, 16'h0000, 16'hFFFF});
      send_word({SEL_RAMP, 16'hFFFF, 16'h0000});
      wait_idle();
   endtask

   task automatic test_dxt5();
      set_format(FMT_DXT5);
      send_word(alpha_word(8'd255, 8'd0));          // eight-step alpha
      send_word({SEL_RAMP, 16'hF800, 16'h07E0});   // c0 < c1 stays four-colour
      send_word(alpha_word(8'd10, 8'd200));         // six-step with 0 and 255
      send_word({SEL_RAMP, 16'hFFFF, 16'h0000});
      send_word(alpha_word(8'd77, 8'd77));
      send_word({SEL_RAMP, 16'h1234, 16'h1234});
      wait_idle();
   endtask

   task automatic test_ordered();
      set_format(FMT_DXT5_ORDERED);
      send_word(alpha_word(8'd200, 8'd3));
      send_word({SEL_RAMP, 16'hF800, 16'h07E0});   // three-colour, alpha from alpha word
      send_word(alpha_word(8'd0, 8'd255));
      send_word({SEL_RAMP, 16'h07E0, 16'hF800});
      wait_idle();
   endtask

   task automatic test_ctx1();
      set_format(FMT_CTX1);
      send_word(alpha_word(8'd0, 8'd255));
      send_word({SEL_RAMP, 8'd0, 8'd255, 8'd255, 8'd0});
      send_word(alpha_word(8'd255, 8'd254));
      send_word({SEL_RAMP, 8'd255, 8'd255, 8'd1, 8'd2});
      wait_idle();
   endtask

   // the alpha/colour phase survives a format change
   task automatic test_phase_carry();
      set_format(FMT_DXT5);
      send_word(alpha_word(8'd90, 8'd30));
      wait_idle();
      set_format(FMT_DXT1);
      send_word({SEL_RAMP, 16'h0841, 16'hC618});
      wait_idle();
      set_format(FMT_CTX1);
      send_word(alpha_word(8'd40, 8'd180));
      wait_idle();
      set_format(FMT_DXT5_ORDERED);
      send_word({SEL_RAMP, 16'hC618, 16'h0841});
      wait_idle();
   endtask

   // rsp held off long enough for the queue to fill and stall req
   task automatic test_backpressure();
      set_format(FMT_DXT1);
      hold_rsp_cycles = 200;
      repeat (10) send_word(random_word());
      wait_idle();
   endtask

   task automatic test_random();
      int phase;
      int n;
      for (phase = 0; phase < 12; phase++) begin
         calm = (phase >= 9);
         set_format(phase < 4 ? 2'(phase) : 2'($urandom_range(0, 3)));
         csr_read_check();
         n = $urandom_range(24, 32);
         repeat (n) send_word(random_word());
         wait_idle();
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= 64'd0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= 3'd0;
      csr_pwdata <= 32'd0;
      fmt_model = FMT_DXT1;
      colour_next = 0;
      alpha_ends = 16'd0;
      alpha_sels = 48'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_csr();
      test_dxt1();
      test_dxt5();
      test_ordered();
      test_ctx1();
      test_phase_carry();
      test_backpressure();
      test_random();

      wait_idle();
      if (error_count == 0 && texel_queue.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
